/* rtl/thtemp_pkg.sv */
package thtemp_pkg;

  localparam int COEF_W   = 48;
  localparam int TEMP_W   = 23;
  localparam int X_W      = 37;
  localparam int ACC_W    = 64;
  localparam int Y_W      = 63;
  localparam int Q_W      = 25;
  localparam int LOG_STEPS = 32;
  localparam int DIV_FIRST = 42;
  localparam int DIV_STEPS = 67 - DIV_FIRST;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic signed [26:0] KELVIN_Q10 = 27'sd279706;
  localparam logic signed [26:0] TEMP_MAX = 27'sd4194303;
  localparam logic signed [26:0] TEMP_MIN = -27'sd4194304;

  localparam logic signed [COEF_W-1:0] COEF0_RST = 48'sd32599033711000;
  localparam logic signed [COEF_W-1:0] COEF1_RST = 48'sd28352663770000;
  localparam logic signed [COEF_W-1:0] COEF2_RST = -48'sd550688039000;
  localparam logic signed [COEF_W-1:0] COEF3_RST = 48'sd29173040900;

  typedef enum logic [1:0] {
    CFG_COEF0 = 2'd0,
    CFG_COEF1 = 2'd1,
    CFG_COEF2 = 2'd2,
    CFG_COEF3 = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic              v;
    logic              z;
    logic              neg;
    logic [X_W-1:0]    x;
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  mag;
    logic [68:0]       pl;
    logic [68:0]       ph;
    logic [61:0]       res;
  } horner_t;

  typedef struct packed {
    logic           v;
    logic           z;
    logic           bad;
    logic [Y_W-1:0] y;
    logic [Y_W-1:0] rem;
    logic [Q_W-1:0] q;
  } div_t;

endpackage

/* rtl/thtemp_if.sv */
interface thtemp_in_if #(parameter int RES_W = 24);
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] resistance;
  modport source (output valid, output resistance, input ready);
  modport sink   (input valid, input resistance, output ready);
endinterface

interface thtemp_out_if;
  logic              valid;
  logic              ready;
  logic signed [22:0] temperature;
  logic [1:0]        status;
  modport source (output valid, output temperature, output status, input ready);
  modport sink   (input valid, input temperature, input status, output ready);
endinterface

/* rtl/thermistor_resistance_to_temperature_core.sv */
// Steinhart-Hart thermistor conversion: each resistance in ohms becomes a Celsius
// temperature in 1/1024 degree with a status (0 ok, 1 zero resistance, 2 out of
// range, saturated). A fully pipelined datapath takes one transaction per cycle
// through one normalize stage, 32 log squaring stages, one ln stage, 13 Horner
// stages, 26 restoring divider stages, one rounding stage and the output register.
// The whole pipeline holds while a result waits at the output. Coefficients must be
// written through the cfg port while the block is idle; the core does not enforce it.
module thermistor_resistance_to_temperature_core #(
  parameter int RESISTANCE_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  thtemp_in_if.sink                  in_ch,
  thtemp_out_if.source               out_ch,
  input  logic                       cfg_we,
  input  thtemp_pkg::cfg_index_t     cfg_index,
  input  logic [thtemp_pkg::COEF_W-1:0] cfg_wdata
);
  import thtemp_pkg::*;

  localparam int NH = 13;

  logic en;
  logic signed [COEF_W-1:0] coef_r [0:3];

  logic             lg_v_r [0:LOG_STEPS];
  logic             lg_z_r [0:LOG_STEPS];
  logic [4:0]       lg_k_r [0:LOG_STEPS];
  logic [31:0]      lg_m_r [0:LOG_STEPS];
  logic [31:0]      lg_f_r [0:LOG_STEPS];

  logic             ln_v_r, ln_z_r;
  logic [63:0]      ln_fl_r;
  logic [X_W-1:0]   ln_kl_r;

  horner_t          hp_r   [0:NH-1];
  horner_t          hp_nxt [0:NH-1];
  div_t             dv_r   [0:DIV_STEPS];
  div_t             dv_nxt [0:DIV_STEPS];

  logic             fa_v_r, fa_z_r, fa_bad_r;
  logic [Q_W:0]     fa_q_r;

  logic             out_v_r;
  logic signed [TEMP_W-1:0] out_temp_r;
  status_t          out_stat_r;

  logic [31:0]      r_ext;
  logic [4:0]       k_nxt;
  logic [31:0]      m_nxt [1:LOG_STEPS];
  logic [31:0]      f_nxt [1:LOG_STEPS];
  logic [63:0]      sq    [1:LOG_STEPS];
  logic [64:0]      fl_sum;
  logic [63:0]      round_bit;
  logic signed [26:0] t_full;
  logic signed [TEMP_W-1:0] temp_nxt;
  status_t          stat_nxt;

  assign en          = out_ch.ready || !out_v_r;
  assign in_ch.ready = en;
  assign out_ch.valid       = out_v_r;
  assign out_ch.temperature = out_temp_r;
  assign out_ch.status      = out_stat_r;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= COEF0_RST;
      coef_r[1] <= COEF1_RST;
      coef_r[2] <= COEF2_RST;
      coef_r[3] <= COEF3_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COEF0: coef_r[0] <= cfg_wdata;
        CFG_COEF1: coef_r[1] <= cfg_wdata;
        CFG_COEF2: coef_r[2] <= cfg_wdata;
        CFG_COEF3: coef_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // leading one and normalize
  always_comb begin
    r_ext = 32'(in_ch.resistance) & 32'((64'd1 << RESISTANCE_BITS) - 64'd1);
    k_nxt = '0;
    for (int i = 0; i < RESISTANCE_BITS; i++) begin
      if (r_ext[i]) k_nxt = 5'(i);
    end
  end

  // log2 fraction by repeated squaring
  always_comb begin
    for (int j = 1; j <= LOG_STEPS; j++) begin
      sq[j] = 64'(lg_m_r[j-1]) * 64'(lg_m_r[j-1]);
      if (sq[j][63]) begin
        m_nxt[j] = sq[j][63:32];
        f_nxt[j] = {lg_f_r[j-1][30:0], 1'b1};
      end else begin
        m_nxt[j] = sq[j][62:31];
        f_nxt[j] = {lg_f_r[j-1][30:0], 1'b0};
      end
    end
  end

  assign round_bit = 64'd1 << 31;
  assign fl_sum    = 65'(ln_fl_r) + 65'(round_bit);

  // horner: negate, multiply halves, sum with rounding, add coefficient
  always_comb begin
    hp_nxt[0]     = hp_r[0];
    hp_nxt[0].v   = ln_v_r;
    hp_nxt[0].z   = ln_z_r;
    hp_nxt[0].x   = ln_kl_r + X_W'(fl_sum[64:32]);
    hp_nxt[0].acc = ACC_W'(coef_r[3]);
    for (int s = 0; s < 3; s++) begin
      hp_nxt[4*s+1]     = hp_r[4*s];
      hp_nxt[4*s+1].neg = hp_r[4*s].acc[ACC_W-1];
      hp_nxt[4*s+1].mag = hp_r[4*s].acc[ACC_W-1] ? -hp_r[4*s].acc : hp_r[4*s].acc;
      hp_nxt[4*s+2]     = hp_r[4*s+1];
      hp_nxt[4*s+2].pl  = 69'(hp_r[4*s+1].mag[31:0]) * 69'(hp_r[4*s+1].x);
      hp_nxt[4*s+2].ph  = 69'(hp_r[4*s+1].mag[63:32]) * 69'(hp_r[4*s+1].x);
      hp_nxt[4*s+3]     = hp_r[4*s+2];
      hp_nxt[4*s+3].res = 62'(({hp_r[4*s+2].ph[61:0], 32'd0}
                               + 94'(hp_r[4*s+2].pl) + 94'(round_bit)) >> 32);
      hp_nxt[4*s+4]     = hp_r[4*s+3];
      hp_nxt[4*s+4].acc = (hp_r[4*s+3].neg ? -64'(hp_r[4*s+3].res) : 64'(hp_r[4*s+3].res))
                          + ACC_W'(coef_r[2-s]);
    end
  end

  // restoring divider of 2^66 by y
  always_comb begin
    dv_nxt[0].v   = hp_r[NH-1].v;
    dv_nxt[0].z   = hp_r[NH-1].z;
    dv_nxt[0].bad = hp_r[NH-1].acc[63] || (hp_r[NH-1].acc[62:42] == '0);
    dv_nxt[0].y   = hp_r[NH-1].acc[Y_W-1:0];
    dv_nxt[0].rem = Y_W'(1) << (DIV_FIRST - 1);
    dv_nxt[0].q   = '0;
    for (int i = 1; i <= DIV_STEPS; i++) begin
      dv_nxt[i] = dv_r[i-1];
      if ({dv_r[i-1].rem, 1'b0} >= {1'b0, dv_r[i-1].y}) begin
        dv_nxt[i].rem = Y_W'({dv_r[i-1].rem, 1'b0} - {1'b0, dv_r[i-1].y});
        dv_nxt[i].q   = {dv_r[i-1].q[Q_W-2:0], 1'b1};
      end else begin
        dv_nxt[i].rem = {dv_r[i-1].rem[Y_W-2:0], 1'b0};
        dv_nxt[i].q   = {dv_r[i-1].q[Q_W-2:0], 1'b0};
      end
    end
  end

  // celsius and saturation
  always_comb begin
    t_full = $signed({1'b0, fa_q_r}) - KELVIN_Q10;
    priority if (fa_z_r) begin
      temp_nxt = '0;
      stat_nxt = ST_ZERO;
    end else if (fa_bad_r || t_full > TEMP_MAX) begin
      temp_nxt = TEMP_W'(TEMP_MAX);
      stat_nxt = ST_RANGE;
    end else if (t_full < TEMP_MIN) begin
      temp_nxt = TEMP_W'(TEMP_MIN);
      stat_nxt = ST_RANGE;
    end else begin
      temp_nxt = TEMP_W'(t_full);
      stat_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= LOG_STEPS; j++) lg_v_r[j] <= 1'b0;
      ln_v_r <= 1'b0;
      for (int h = 0; h < NH; h++) hp_r[h].v <= 1'b0;
      for (int i = 0; i <= DIV_STEPS; i++) dv_r[i].v <= 1'b0;
      fa_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      lg_v_r[0] <= in_ch.valid;
      lg_z_r[0] <= (r_ext == '0);
      lg_k_r[0] <= k_nxt;
      lg_m_r[0] <= r_ext << (5'd31 - k_nxt);
      lg_f_r[0] <= '0;
      for (int j = 1; j <= LOG_STEPS; j++) begin
        lg_v_r[j] <= lg_v_r[j-1];
        lg_z_r[j] <= lg_z_r[j-1];
        lg_k_r[j] <= lg_k_r[j-1];
        lg_m_r[j] <= m_nxt[j];
        lg_f_r[j] <= f_nxt[j];
      end
      ln_v_r  <= lg_v_r[LOG_STEPS];
      ln_z_r  <= lg_z_r[LOG_STEPS];
      ln_fl_r <= 64'(lg_f_r[LOG_STEPS]) * 64'(LN2_Q32);
      ln_kl_r <= X_W'(lg_k_r[LOG_STEPS]) * X_W'(LN2_Q32);
      for (int h = 0; h < NH; h++) hp_r[h] <= hp_nxt[h];
      for (int i = 0; i <= DIV_STEPS; i++) dv_r[i] <= dv_nxt[i];
      fa_v_r   <= dv_r[DIV_STEPS].v;
      fa_z_r   <= dv_r[DIV_STEPS].z;
      fa_bad_r <= dv_r[DIV_STEPS].bad;
      fa_q_r   <= {1'b0, dv_r[DIV_STEPS].q}
                  + (Q_W+1)'({dv_r[DIV_STEPS].rem, 1'b0} >= {1'b0, dv_r[DIV_STEPS].y});
      out_v_r    <= fa_v_r;
      out_temp_r <= temp_nxt;
      out_stat_r <= stat_nxt;
    end
  end

endmodule

/* tb/thermistor_resistance_to_temperature_core_tb.sv */
`timescale 1ns / 100ps

module thermistor_resistance_to_temperature_core_tb;
  import thtemp_pkg::*;

  localparam int LATENCY = 75;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_index_t cfg_index;
  logic [COEF_W-1:0] cfg_wdata;

  thtemp_in_if #(.RES_W(24)) in_ch ();
  thtemp_out_if out_ch ();

  thermistor_resistance_to_temperature_core #(.RESISTANCE_BITS(24)) u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  typedef struct packed {
    logic signed [22:0] temperature;
    status_t status;
  } reading_t;

  logic signed [47:0] coef_q56 [4];
  reading_t expected_readings[$];
  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [63:0] ln_q32(logic [63:0] r);
    int k;
    logic [63:0] m;
    logic [63:0] frac;
    k = 31;
    frac = 0;
    while (k > 0 && r[k] == 1'b0) k--;
    m = r << (31 - k);
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return 64'(k) * 64'(LN2_Q32) + ((frac * 64'(LN2_Q32) + 64'h8000_0000) >> 32);
  endfunction

  function automatic logic signed [63:0] mul_round(logic signed [63:0] a, logic [63:0] x);
    logic [127:0] p;
    logic [63:0] mag;
    logic [63:0] res;
    mag = (a < 0) ? -a : a;
    p = 128'(mag) * 128'(x);
    res = 64'((p >> 32) + 128'(p[31]));
    res[63:62] = 2'b00;
    return (a < 0) ? -$signed(res) : $signed(res);
  endfunction

  function automatic reading_t convert(logic [23:0] r);
    reading_t o;
    logic [63:0] x;
    logic signed [63:0] acc;
    logic [66:0] num;
    logic [66:0] q;
    logic signed [67:0] t;
    if (r == 0) begin
      o.temperature = 0;
      o.status = ST_ZERO;
      return o;
    end
    x = ln_q32(64'(r));
    acc = 64'(coef_q56[3]);
    acc = mul_round(acc, x) + 64'(coef_q56[2]);
    acc = mul_round(acc, x) + 64'(coef_q56[1]);
    acc = mul_round(acc, x) + 64'(coef_q56[0]);
    o.status = ST_OK;
    if (acc < (64'sd1 <<< 42)) begin
      o.temperature = TEMP_MAX[22:0];
      o.status = ST_RANGE;
      return o;
    end
    num = 67'd1 << 66;
    q = num / 67'(acc);
    if (((num % 67'(acc)) << 1) >= 67'(acc)) q = q + 1;
    t = $signed({1'b0, q}) - 68'sd279706;
    if (t > 68'sd4194303) begin
      o.temperature = TEMP_MAX[22:0];
      o.status = ST_RANGE;
    end else if (t < -68'sd4194304) begin
      o.temperature = TEMP_MIN[22:0];
      o.status = ST_RANGE;
    end else begin
      o.temperature = t[22:0];
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  task automatic write_coef(cfg_index_t idx, logic signed [47:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    coef_q56[idx] = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_resistance(logic [23:0] r);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.resistance = r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_readings.push_back(convert(r));
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic drain;
    while (expected_readings.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [23:0] random_resistance;
    case ($urandom_range(3))
      0: return 24'($urandom_range(1, 255));
      1: return 24'($urandom_range(1000, 200000));
      2: return 24'(1) << $urandom_range(23);
      default: return 24'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        reading_t e;
        e = expected_readings.pop_front();
        if (out_ch.temperature !== e.temperature)
          report_mismatch("temperature", out_ch.temperature, e.temperature);
        if (out_ch.status !== e.status)
          report_mismatch("status", out_ch.status, e.status);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  task automatic test_directed;
    logic [23:0] vals [14] = '{24'd0, 24'd1, 24'd2, 24'd3, 24'd100, 24'd1000, 24'd10000,
                               24'd100000, 24'd8388608, 24'd16777215, 24'h555555,
                               24'haaaaaa, 24'd32, 24'd4000000};
    foreach (vals[i]) send_resistance(vals[i]);
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_resistance(random_resistance());
  endtask

  task automatic test_idling;
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(300);
    send_idle_pct = 65; recv_stall_pct = 0;  test_random(250);
    send_idle_pct = 0;  recv_stall_pct = 65; test_random(250);
    send_idle_pct = 13; recv_stall_pct = 13; test_random(250);
    send_idle_pct = 0;  recv_stall_pct = 0;
    drain();
  endtask

  task automatic test_backpressure;
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(200);
    join
    drain();
  endtask

  task automatic test_coefficients;
    // beta model
    write_coef(CFG_COEF2, 48'sd0);
    write_coef(CFG_COEF3, 48'sd0);
    test_directed();
    test_random(100);
    drain();
    // extremes and negative inverse
    write_coef(CFG_COEF0, 48'sh7FFF_FFFF_FFFF);
    write_coef(CFG_COEF1, 48'sh8000_0000_0000);
    write_coef(CFG_COEF2, 48'sh7FFF_FFFF_FFFF);
    write_coef(CFG_COEF3, 48'sh8000_0000_0000);
    test_random(100);
    drain();
    write_coef(CFG_COEF0, 48'sh8000_0000_0000);
    write_coef(CFG_COEF1, 48'sd0);
    write_coef(CFG_COEF2, 48'sd0);
    write_coef(CFG_COEF3, 48'sd0);
    test_random(30);
    drain();
    // small constant inverse: far too hot and just out of range
    write_coef(CFG_COEF0, 48'sd1 <<< 42);
    test_random(30);
    drain();
    write_coef(CFG_COEF0, 48'sd14000000000);
    test_random(30);
    drain();
    for (int p = 0; p < 4; p++) begin
      write_coef(CFG_COEF0, 48'($urandom_range(1000, 60000)) * 48'd1000000000);
      write_coef(CFG_COEF1, $signed(48'($urandom)) * 48'sd100);
      write_coef(CFG_COEF2, -$signed(48'($urandom)) * 48'sd2);
      write_coef(CFG_COEF3, $signed(48'($urandom_range(0, 60000))) * 48'sd1000);
      test_random(60);
      drain();
    end
    write_coef(CFG_COEF0, COEF0_RST);
    write_coef(CFG_COEF1, COEF1_RST);
    write_coef(CFG_COEF2, COEF2_RST);
    write_coef(CFG_COEF3, COEF3_RST);
    test_random(50);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_COEF0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.resistance = '0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    coef_q56[0] = COEF0_RST;
    coef_q56[1] = COEF1_RST;
    coef_q56[2] = COEF2_RST;
    coef_q56[3] = COEF3_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_idling();
    test_backpressure();
    test_coefficients();
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
